// ===== hdl/dcf77_frame_modulator_macros.svh =====
// Assertion macros shared by the time-code modulator checks.
`ifndef DCF77_FRAME_MODULATOR_MACROS_SVH
`define DCF77_FRAME_MODULATOR_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled while arst_n is low.
`define DCF_CHECK_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and disabled while arst_n is low.
`define DCF_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/dcf77_pkg.sv =====
// Types, constants and phase-step functions of the time-code modulator.
package dcf77_pkg;

	localparam int FRAME_W      = 59;
	localparam int FRAME_LENGTH = 59;
	localparam int MS_W         = 16;
	localparam int POS_W        = 6;
	localparam int CFG_IDX_W    = 3;
	localparam int SKIP_STEPS   = 4;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_FRAME  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ONE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MARKER = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFF    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ON     = 3'd6;

	// Reset values of the configuration registers.
	localparam logic [MS_W-1:0] RST_PERIOD_MS = 16'd970;
	localparam logic [MS_W-1:0] RST_ZERO_MS   = 16'd100;
	localparam logic [MS_W-1:0] RST_ONE_MS    = 16'd200;
	localparam logic [MS_W-1:0] RST_MARKER_MS = 16'd850;
	localparam logic [MS_W-1:0] RST_OFF_MS    = 16'd3000;
	localparam logic [MS_W-1:0] RST_ON_MS     = 16'd1800;

	// Carrier levels.
	localparam logic [1:0] LVL_OFF     = 2'd0;
	localparam logic [1:0] LVL_REDUCED = 2'd1;
	localparam logic [1:0] LVL_FULL    = 2'd2;

	typedef enum logic [2:0] {
		PH_OFF   = 3'd0,
		PH_ON    = 3'd1,
		PH_PULSE = 3'd2,
		PH_GAP   = 3'd3,
		PH_MARK  = 3'd4
	} phase_t;

	typedef struct packed {
		logic [FRAME_W-1:0] time_code;
		logic [MS_W-1:0]    bit_period_ms;
		logic [MS_W-1:0]    zero_pulse_ms;
		logic [MS_W-1:0]    one_pulse_ms;
		logic [MS_W-1:0]    marker_ms;
		logic [MS_W-1:0]    initial_off_ms;
		logic [MS_W-1:0]    initial_on_ms;
	} cfg_t;

	typedef struct packed {
		phase_t           phase;
		logic [MS_W-1:0]  rem;
		logic [POS_W-1:0] pos;
		logic             bit_val;
	} seq_state_t;

	typedef struct packed {
		logic [1:0]       carrier_level;
		phase_t           phase;
		logic [POS_W-1:0] bit_number;
		logic             current_bit;
		logic             second_start;
	} res_t;

	// Frame bit sent at a given position; position 0 is the highest frame bit.
	function automatic logic frame_bit(input logic [FRAME_W-1:0] frame,
			input logic [POS_W-1:0] pos);
		logic [POS_W-1:0] idx;
		idx = POS_W'(FRAME_LENGTH - 1) - pos;
		return frame[idx];
	endfunction

	// Start the pulse of the bit at the given position.
	function automatic seq_state_t enter_bit(input seq_state_t s, input cfg_t c,
			input logic [POS_W-1:0] pos);
		seq_state_t n;
		n         = s;
		n.pos     = pos;
		n.bit_val = frame_bit(c.time_code, pos);
		n.phase   = PH_PULSE;
		n.rem     = n.bit_val ? c.one_pulse_ms : c.zero_pulse_ms;
		return n;
	endfunction

	// Move on to the next phase and load its length.
	function automatic seq_state_t advance(input seq_state_t s, input cfg_t c,
			input logic [MS_W-1:0] gap0, input logic [MS_W-1:0] gap1);
		seq_state_t n;
		n = s;
		unique case (s.phase)
			PH_OFF: begin
				n.phase = PH_ON;
				n.rem   = c.initial_on_ms;
			end
			PH_ON, PH_MARK: begin
				n = enter_bit(s, c, POS_W'(0));
			end
			PH_PULSE: begin
				n.phase = PH_GAP;
				n.rem   = s.bit_val ? gap1 : gap0;
			end
			PH_GAP: begin
				if (s.pos >= POS_W'(FRAME_LENGTH - 1)) begin
					n.phase = PH_MARK;
					n.rem   = c.marker_ms;
				end else begin
					n = enter_bit(s, c, s.pos + POS_W'(1));
				end
			end
			default: begin
				n.phase = PH_OFF;
				n.rem   = c.initial_off_ms;
			end
		endcase
		return n;
	endfunction

endpackage

// ===== hdl/dcf77_frame_modulator.sv =====
// A tick request accepted into the input stage has its result written to the result register.
// Throughput: one tick per cycle while the result is not stalled; up to four empty phases are passed over per tick.
// A stalled result keeps its register while the next tick waits in the input stage.
// Reset (arst_n low) loads the register defaults and starts in the carrier-off phase.
// Configuration writes are always taken and act on phases entered afterwards.
`include "dcf77_frame_modulator_macros.svh"

module dcf77_frame_modulator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              tick_valid,
	output logic                              tick_stall,
	input  logic                              restart,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic [1:0]                        carrier_level,
	output logic [2:0]                        phase_code,
	output logic [dcf77_pkg::POS_W-1:0]       bit_number,
	output logic                              current_bit,
	output logic                              second_start,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dcf77_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dcf77_pkg::FRAME_W-1:0]     cfg_data
);
	import dcf77_pkg::*;

	cfg_t  cfg;
	res_t  result;
	res_t  res_q;
	logic  res_valid_q;
	logic  valid_s1;
	logic  restart_s1;
	logic  step;
	logic  tick_accept;

	// Handshake control: the input stage moves on whenever the result register is free.
	assign cfg_ready   = 1'b1;
	assign step        = !res_valid_q || !res_stall;
	assign tick_stall  = valid_s1 && !step;
	assign tick_accept = tick_valid && !tick_stall;

	dcf77_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	dcf77_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (valid_s1 && step),
		.restart (restart_s1),
		.cfg     (cfg),
		.result  (result)
	);

	// Valid flags of the input stage and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			valid_s1 <= tick_accept || (valid_s1 && !step);
			if (step) begin
				res_valid_q <= valid_s1;
			end
		end
	end

	// Payload registers of the input stage and the result.
	always_ff @(posedge clk) begin
		if (tick_accept) begin
			restart_s1 <= restart;
		end
		if (valid_s1 && step) begin
			res_q <= result;
		end
	end

	assign res_valid     = res_valid_q;
	assign carrier_level = res_q.carrier_level;
	assign phase_code    = res_q.phase;
	assign bit_number    = res_q.bit_number;
	assign current_bit   = res_q.current_bit;
	assign second_start  = res_q.second_start;

	// Checks on the sequencer and the stage control.
	`DCF_CHECK_NOW(a_pulse_level, res_valid_q && phase_code == PH_PULSE, carrier_level == LVL_REDUCED, "pulse phase without reduced level")
	`DCF_CHECK_NOW(a_start_in_pulse, res_valid_q && second_start, phase_code == PH_PULSE, "second start outside a pulse")
	`DCF_CHECK_NOW(a_bit_range, res_valid_q, bit_number <= POS_W'(FRAME_LENGTH - 1), "bit number beyond the frame")
	`DCF_CHECK_NEXT(a_stage_moves, valid_s1 && step, res_valid_q, "processed tick gave no result")

endmodule

// ===== hdl/dcf77_cfg.sv =====
// Configuration register bank of the time-code modulator.
module dcf77_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [dcf77_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [dcf77_pkg::FRAME_W-1:0]        wr_data,
	output dcf77_pkg::cfg_t                      cfg
);
	import dcf77_pkg::*;

	cfg_t cfg_q;

	// Register write decode; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_code      <= '0;
			cfg_q.bit_period_ms  <= RST_PERIOD_MS;
			cfg_q.zero_pulse_ms  <= RST_ZERO_MS;
			cfg_q.one_pulse_ms   <= RST_ONE_MS;
			cfg_q.marker_ms      <= RST_MARKER_MS;
			cfg_q.initial_off_ms <= RST_OFF_MS;
			cfg_q.initial_on_ms  <= RST_ON_MS;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_FRAME:  cfg_q.time_code      <= wr_data;
				REG_PERIOD: cfg_q.bit_period_ms  <= wr_data[MS_W-1:0];
				REG_ZERO:   cfg_q.zero_pulse_ms  <= wr_data[MS_W-1:0];
				REG_ONE:    cfg_q.one_pulse_ms   <= wr_data[MS_W-1:0];
				REG_MARKER: cfg_q.marker_ms      <= wr_data[MS_W-1:0];
				REG_OFF:    cfg_q.initial_off_ms <= wr_data[MS_W-1:0];
				REG_ON:     cfg_q.initial_on_ms  <= wr_data[MS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/dcf77_seq.sv =====
// Phase sequencer: holds the phase state and works out the result of one tick.
module dcf77_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic            restart,
	input  dcf77_pkg::cfg_t cfg,
	output dcf77_pkg::res_t result
);
	import dcf77_pkg::*;

	seq_state_t       state_q;
	seq_state_t       state_n;
	seq_state_t       st;
	logic             entered;
	logic [MS_W-1:0]  period_eff;
	logic [MS_W-1:0]  gap0;
	logic [MS_W-1:0]  gap1;

	// Gap lengths for both bit values, saturated at zero; a zero period counts as one.
	always_comb begin
		period_eff = (cfg.bit_period_ms == '0) ? MS_W'(1) : cfg.bit_period_ms;
		gap0 = (cfg.zero_pulse_ms >= period_eff) ? '0 : period_eff - cfg.zero_pulse_ms;
		gap1 = (cfg.one_pulse_ms >= period_eff) ? '0 : period_eff - cfg.one_pulse_ms;
	end

	// Restart, then pass over phases with no time left. At most four phases can be
	// empty in a row, as a zero-length pulse is always followed by a non-empty gap.
	always_comb begin
		if (restart) begin
			st.phase   = PH_OFF;
			st.rem     = cfg.initial_off_ms;
			st.pos     = '0;
			st.bit_val = 1'b0;
		end else begin
			st = state_q;
		end
		entered = 1'b0;
		for (int i = 0; i < SKIP_STEPS; i++) begin
			if (st.rem == '0) begin
				st = advance(st, cfg, gap0, gap1);
				if (st.phase == PH_PULSE) begin
					entered = 1'b1;
				end
			end
		end
	end

	// Result fields and the countdown for the next tick.
	always_comb begin
		case (st.phase)
			PH_OFF:   result.carrier_level = LVL_OFF;
			PH_PULSE: result.carrier_level = LVL_REDUCED;
			default:  result.carrier_level = LVL_FULL;
		endcase
		result.phase = st.phase;
		if (st.phase == PH_PULSE || st.phase == PH_GAP) begin
			result.bit_number  = st.pos;
			result.current_bit = st.bit_val;
		end else begin
			result.bit_number  = '0;
			result.current_bit = 1'b0;
		end
		result.second_start = (st.phase == PH_PULSE) && entered;
		state_n     = st;
		state_n.rem = st.rem - MS_W'(1);
	end

	// Phase state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase   <= PH_OFF;
			state_q.rem     <= RST_OFF_MS;
			state_q.pos     <= '0;
			state_q.bit_val <= 1'b0;
		end else if (step) begin
			state_q <= state_n;
		end
	end

endmodule
